// ===== src/dhcp_reply_wpad_extractor_assert.svh =====
// assertion helpers for the wpad extractor
`ifndef DHCP_REPLY_WPAD_EXTRACTOR_ASSERT_SVH
`define DHCP_REPLY_WPAD_EXTRACTOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DWPAD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dwpad assertion failed");

// next-cycle implication, checked out of reset
`define DWPAD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dwpad assertion failed");

`endif

// ===== src/dwpad_pkg.sv =====
`default_nettype none

package dwpad_pkg;

    // number of result entries buffered ahead of the output port
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic ITEM_URL     = 1'b0;
    localparam logic ITEM_VERDICT = 1'b1;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] url_byte;
        logic       verdict_ok;
        logic       is_last;
    } result_t;

    // results produced by one input beat, in delivery order
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

`default_nettype wire

// ===== src/dwpad_parser.sv =====
`default_nettype none

module dwpad_parser #(
    parameter int MAX_OPTIONS_BYTES = 312
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire logic [7:0]        rx_byte,
    input  wire logic              rx_last,
    input  wire logic [31:0]       expected_xid,
    output dwpad_pkg::push_t       push
);

    localparam logic [2:0] PH_HEADER    = 3'd0;
    localparam logic [2:0] PH_CODE      = 3'd1;
    localparam logic [2:0] PH_MSG_LEN   = 3'd2;
    localparam logic [2:0] PH_MSG_VAL   = 3'd3;
    localparam logic [2:0] PH_SKIP_LEN  = 3'd4;
    localparam logic [2:0] PH_WPAD_LEN  = 3'd5;
    localparam logic [2:0] PH_WPAD_DATA = 3'd6;
    localparam logic [2:0] PH_DONE      = 3'd7;

    localparam logic [9:0] OPTIONS_START = 10'd240;
    localparam logic [9:0] POS_CAP       = 10'd1023;
    localparam logic [9:0] POS_LIMIT     = 10'(236 + MAX_OPTIONS_BYTES);
    localparam logic [9:0] XID_FIRST     = 10'd4;
    localparam logic [9:0] XID_LAST      = 10'd7;
    localparam logic [9:0] COOKIE_FIRST  = 10'd236;
    localparam logic [9:0] COOKIE_LAST   = 10'd239;

    localparam logic [7:0] OP_BOOTREPLY  = 8'd2;
    localparam logic [7:0] OPT_END       = 8'd255;
    localparam logic [7:0] OPT_MSGTYPE   = 8'd53;
    localparam logic [7:0] OPT_WPAD      = 8'd252;
    localparam logic [7:0] MSG_ACK       = 8'd5;

    localparam logic [7:0] COOKIE [4] = '{8'd99, 8'd130, 8'd83, 8'd99};

    logic [9:0] pos_reg,     pos_next;
    logic [2:0] phase_reg,   phase_next;
    logic [7:0] skip_reg,    skip_next;
    logic [9:0] ncp_reg,     ncp_next;
    logic       failed_reg,  failed_next;
    logic       found_reg,   found_next;

    logic       fail;
    logic       hdr_bad;
    logic       url_vld;
    logic       ok;
    logic [7:0] xid_byte;
    dwpad_pkg::result_t url_item;
    dwpad_pkg::result_t verdict_item;

    // first wire byte of the xid is the most significant
    assign xid_byte = 8'(expected_xid >> {~pos_reg[1:0], 3'b000});

    always_comb begin
        pos_next    = pos_reg;
        phase_next  = phase_reg;
        skip_next   = skip_reg;
        ncp_next    = ncp_reg;
        failed_next = failed_reg;
        found_next  = found_reg;
        fail        = 1'b0;
        url_vld     = 1'b0;

        hdr_bad = ((pos_reg == 10'd0) && (rx_byte != OP_BOOTREPLY)) ||
                  ((pos_reg >= XID_FIRST) && (pos_reg <= XID_LAST) &&
                   (rx_byte != xid_byte)) ||
                  ((pos_reg >= COOKIE_FIRST) && (pos_reg <= COOKIE_LAST) &&
                   (rx_byte != COOKIE[pos_reg[1:0]]));

        if (pos_reg >= POS_LIMIT) begin
            fail = 1'b1;
        end else begin
            case (phase_reg)
                PH_HEADER: begin
                    if (hdr_bad) begin
                        fail = 1'b1;
                    end else if (pos_reg == OPTIONS_START - 10'd1) begin
                        phase_next = PH_CODE;
                    end
                end
                PH_CODE: begin
                    if (pos_reg == ncp_reg) begin
                        if (rx_last || (rx_byte == OPT_END)) begin
                            fail = 1'b1;
                        end else if (rx_byte == OPT_MSGTYPE) begin
                            phase_next = PH_MSG_LEN;
                        end else if (rx_byte == OPT_WPAD) begin
                            phase_next = PH_WPAD_LEN;
                        end else begin
                            phase_next = PH_SKIP_LEN;
                        end
                    end
                end
                PH_MSG_LEN: begin
                    if ((rx_byte != 8'd1) || rx_last) begin
                        fail = 1'b1;
                    end else begin
                        phase_next = PH_MSG_VAL;
                    end
                end
                PH_MSG_VAL: begin
                    if (rx_byte != MSG_ACK) begin
                        fail = 1'b1;
                    end else begin
                        ncp_next   = pos_reg + 10'd1;
                        phase_next = PH_CODE;
                    end
                end
                PH_SKIP_LEN: begin
                    ncp_next   = pos_reg + 10'd1 + {2'b00, rx_byte};
                    phase_next = PH_CODE;
                end
                PH_WPAD_LEN: begin
                    if (rx_last) begin
                        fail = 1'b1;
                    end else begin
                        found_next = 1'b1;
                        skip_next  = rx_byte;
                        phase_next = (rx_byte == 8'd0) ? PH_DONE : PH_WPAD_DATA;
                    end
                end
                PH_WPAD_DATA: begin
                    if (rx_byte == 8'd0) begin
                        phase_next = PH_DONE;
                    end else begin
                        url_vld   = 1'b1;
                        skip_next = skip_reg - 8'd1;
                        if (skip_reg == 8'd1) begin
                            phase_next = PH_DONE;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        if (fail) begin
            failed_next = 1'b1;
            phase_next  = PH_DONE;
        end

        ok = !failed_next && found_next;

        // verdict closes the datagram, state starts over
        if (rx_last) begin
            pos_next    = 10'd0;
            phase_next  = PH_HEADER;
            skip_next   = 8'd0;
            ncp_next    = OPTIONS_START;
            failed_next = 1'b0;
            found_next  = 1'b0;
        end else if (pos_reg < POS_CAP) begin
            pos_next = pos_reg + 10'd1;
        end
    end

    always_comb begin
        url_item.item_kind      = dwpad_pkg::ITEM_URL;
        url_item.url_byte       = rx_byte;
        url_item.verdict_ok     = 1'b0;
        url_item.is_last        = 1'b0;
        verdict_item.item_kind  = dwpad_pkg::ITEM_VERDICT;
        verdict_item.url_byte   = 8'd0;
        verdict_item.verdict_ok = ok;
        verdict_item.is_last    = 1'b1;

        push.count  = step ? (2'(url_vld) + 2'(rx_last)) : 2'd0;
        push.first  = url_vld ? url_item : verdict_item;
        push.second = verdict_item;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= 10'd0;
            phase_reg  <= PH_HEADER;
            skip_reg   <= 8'd0;
            ncp_reg    <= OPTIONS_START;
            failed_reg <= 1'b0;
            found_reg  <= 1'b0;
        end else if (step) begin
            pos_reg    <= pos_next;
            phase_reg  <= phase_next;
            skip_reg   <= skip_next;
            ncp_reg    <= ncp_next;
            failed_reg <= failed_next;
            found_reg  <= found_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/dwpad_out_fifo.sv =====
`default_nettype none

module dwpad_out_fifo (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire dwpad_pkg::push_t    push,
    input  wire logic                pop,
    output dwpad_pkg::result_t       head,
    output logic                     not_empty,
    output logic                     room_for_two
);

    localparam int AW = dwpad_pkg::FIFO_AW;
    localparam logic [AW:0] DEPTH = (AW + 1)'(dwpad_pkg::FIFO_DEPTH);

    dwpad_pkg::result_t mem [dwpad_pkg::FIFO_DEPTH];

    logic [AW-1:0] wr_reg, wr_next;
    logic [AW-1:0] rd_reg, rd_next;
    logic [AW:0]   cnt_reg, cnt_next;

    assign head         = mem[rd_reg];
    assign not_empty    = (cnt_reg != '0);
    assign room_for_two = (cnt_reg <= DEPTH - (AW + 1)'(2));

    always_comb begin
        wr_next  = wr_reg + AW'(push.count);
        rd_next  = rd_reg + AW'(pop);
        cnt_next = cnt_reg + (AW + 1)'(push.count) - (AW + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem[wr_reg + AW'(1)] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/dhcp_reply_wpad_extractor.sv =====
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tdata[7:0] rx_byte, tlast rx_last
// m_axis    out  m_axis_tvalid/tready       tdata url_byte, verdict_ok; tlast is_last;
//                                           tuser item_kind
// cfg       in   cfg_valid/cfg_ready        cfg_data expected_xid
//
// one input beat per cycle sustained; a beat is held in the input
// register, then its results land in a four-entry result queue
// a final byte carrying wpad data yields two results, drained one per cycle while m_axis_tready is high
// input stalls only when the result queue has fewer than two free entries
// reset is synchronous active low: parse state and queue clear, xid goes to 0
`default_nettype none

module dhcp_reply_wpad_extractor #(
    parameter int MAX_OPTIONS_BYTES = 312
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // input byte stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  wire logic        s_axis_tlast,   // rx_last

    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] url_byte, [8] verdict_ok, rest zero
    output logic             m_axis_tlast,   // is_last
    output logic [0:0]       m_axis_tuser,   // [0] item_kind

    // transaction id register
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data
);

    // input register
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    logic [31:0] xid_reg;

    logic advance;
    logic room_for_two;
    logic not_empty;
    logic pop;

    dwpad_pkg::push_t   push;
    dwpad_pkg::result_t head;

    // parse the held beat when the queue can take both possible results
    assign advance       = in_vld_reg && room_for_two;
    assign s_axis_tready = !in_vld_reg || advance;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xid_reg <= 32'd0;
        end else if (cfg_valid && cfg_ready) begin
            xid_reg <= cfg_data;
        end
    end

    dwpad_parser #(
        .MAX_OPTIONS_BYTES (MAX_OPTIONS_BYTES)
    ) u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .rx_byte      (in_byte_reg),
        .rx_last      (in_last_reg),
        .expected_xid (xid_reg),
        .push         (push)
    );

    dwpad_out_fifo u_out_fifo (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push         (push),
        .pop          (pop),
        .head         (head),
        .not_empty    (not_empty),
        .room_for_two (room_for_two)
    );

    // queue head drives the output beat directly
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = not_empty;
    assign m_axis_tdata  = {7'd0, head.verdict_ok, head.url_byte};
    assign m_axis_tlast  = head.is_last;
    assign m_axis_tuser  = head.item_kind;

`include "dhcp_reply_wpad_extractor_assert.svh"

    // a verdict beat always closes the datagram and carries no url byte
    `DWPAD_ASSERT_NOW(a_verdict_shape, aclk, aresetn, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast && (m_axis_tdata[7:0] == 8'd0))

    // url beats never end a datagram nor claim success
    `DWPAD_ASSERT_NOW(a_url_shape, aclk, aresetn, m_axis_tvalid && !m_axis_tuser[0], !m_axis_tlast && !m_axis_tdata[8])

    // a held beat that cannot advance stays put in the input register
    `DWPAD_ASSERT_NEXT(a_input_hold, aclk, aresetn, in_vld_reg && !advance, in_vld_reg && $stable(in_byte_reg) && $stable(in_last_reg))

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    // block parameter and the layout of a dhcp reply
    localparam int OPTIONS_LIMIT = 312;
    localparam int OPTIONS_START = 240;
    localparam int POS_MAX       = 1023;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_REPLIES = 16;

    localparam logic [7:0]  OP_BOOTREPLY = 8'd2;
    localparam logic [7:0]  OPT_PAD      = 8'd0;
    localparam logic [7:0]  OPT_MSGTYPE  = 8'd53;
    localparam logic [7:0]  OPT_WPAD     = 8'd252;
    localparam logic [7:0]  OPT_END      = 8'd255;
    localparam logic [7:0]  MSG_OFFER    = 8'd2;
    localparam logic [7:0]  MSG_ACK      = 8'd5;
    localparam logic [31:0] MAGIC_COOKIE = {8'd99, 8'd130, 8'd83, 8'd99};

    // where the option walk stands
    typedef enum logic [2:0] {
        WALK_HEADER,
        WALK_CODE,
        WALK_MSG_LEN,
        WALK_MSG_VAL,
        WALK_SKIP_LEN,
        WALK_WPAD_LEN,
        WALK_WPAD_DATA,
        WALK_DONE
    } walk_phase_e;

    // tracks the reply walk and holds the url bytes and verdicts still due
    class wpad_reply_checker;
        logic [31:0]        xid;
        walk_phase_e        phase;
        int                 pos;
        int                 next_code;
        logic [7:0]         url_left;
        bit                 failed;
        bit                 found;
        dwpad_pkg::result_t expected_items[$];
        int                 errors;

        function new();
            xid    = '0;
            errors = 0;
            clear_walk();
        endfunction

        function void clear_walk();
            pos       = 0;
            phase     = WALK_HEADER;
            url_left  = '0;
            next_code = OPTIONS_START;
            failed    = 1'b0;
            found     = 1'b0;
        endfunction

        function void abort_walk();
            failed = 1'b1;
            phase  = WALK_DONE;
        endfunction

        function void log_error(string msg);
            errors++;
            if (errors <= 10) $display("error: %s", msg);
        endfunction

        function dwpad_pkg::result_t make_result(logic kind, logic [7:0] b, logic ok,
                                                 logic last);
            dwpad_pkg::result_t r;
            r.item_kind  = kind;
            r.url_byte   = b;
            r.verdict_ok = ok;
            r.is_last    = last;
            return r;
        endfunction

        function int pending();
            return expected_items.size();
        endfunction

        // one accepted input beat
        function void note_rx_byte(logic [7:0] b, logic last);
            if (pos >= 236 + OPTIONS_LIMIT) begin
                abort_walk();
            end else begin
                case (phase)
                    WALK_HEADER: begin
                        if (pos == 0 && b != OP_BOOTREPLY)
                            abort_walk();
                        else if (pos >= 4 && pos <= 7 && b != xid[8*(7-pos) +: 8])
                            abort_walk();
                        else if (pos >= 236 && pos <= 239 &&
                                 b != MAGIC_COOKIE[8*(239-pos) +: 8])
                            abort_walk();
                        if (!failed && pos == OPTIONS_START - 1) phase = WALK_CODE;
                    end
                    WALK_CODE: begin
                        if (pos == next_code) begin
                            if (last || b == OPT_END) abort_walk();
                            else if (b == OPT_MSGTYPE) phase = WALK_MSG_LEN;
                            else if (b == OPT_WPAD) phase = WALK_WPAD_LEN;
                            else phase = WALK_SKIP_LEN;
                        end
                    end
                    WALK_MSG_LEN: begin
                        if (b != 8'd1 || last) abort_walk();
                        else phase = WALK_MSG_VAL;
                    end
                    WALK_MSG_VAL: begin
                        if (b != MSG_ACK) begin
                            abort_walk();
                        end else begin
                            next_code = pos + 1;
                            phase     = WALK_CODE;
                        end
                    end
                    WALK_SKIP_LEN: begin
                        next_code = pos + 1 + int'(b);
                        phase     = WALK_CODE;
                    end
                    WALK_WPAD_LEN: begin
                        if (last) begin
                            abort_walk();
                        end else begin
                            found    = 1'b1;
                            url_left = b;
                            phase    = (b == 8'd0) ? WALK_DONE : WALK_WPAD_DATA;
                        end
                    end
                    WALK_WPAD_DATA: begin
                        if (b == 8'd0) begin
                            phase = WALK_DONE;
                        end else begin
                            expected_items.push_back(
                                make_result(dwpad_pkg::ITEM_URL, b, 1'b0, 1'b0));
                            url_left = url_left - 8'd1;
                            if (url_left == 8'd0) phase = WALK_DONE;
                        end
                    end
                    default: ;
                endcase
            end

            if (last) begin
                expected_items.push_back(make_result(dwpad_pkg::ITEM_VERDICT, 8'd0,
                                                     !failed && found, 1'b1));
                clear_walk();
            end else if (pos < POS_MAX) begin
                pos++;
            end
        endfunction

        // one accepted output beat
        function void check_result(dwpad_pkg::result_t got);
            dwpad_pkg::result_t want;
            if (expected_items.size() == 0) begin
                log_error($sformatf("result with nothing pending: kind %0d url %02h ok %0d last %0d",
                                    got.item_kind, got.url_byte, got.verdict_ok, got.is_last));
                return;
            end
            want = expected_items.pop_front();
            if (got.item_kind !== want.item_kind || got.url_byte !== want.url_byte ||
                got.verdict_ok !== want.verdict_ok || got.is_last !== want.is_last)
                log_error($sformatf({"expected kind %0d url %02h ok %0d last %0d, ",
                                     "got kind %0d url %02h ok %0d last %0d"},
                                    want.item_kind, want.url_byte, want.verdict_ok,
                                    want.is_last, got.item_kind, got.url_byte,
                                    got.verdict_ok, got.is_last));
        endfunction
    endclass

    // clock and dut ports
    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
    logic        s_axis_tlast;   // rx_last
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [7:0] url_byte, [8] verdict_ok, rest zero
    logic        m_axis_tlast;   // is_last
    logic [0:0]  m_axis_tuser;   // [0] item_kind
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    // idle percentages for each side, and the receiver hold-off count
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;

    // datagram under construction, one entry per wire byte
    logic [7:0] dgram[$];

    wpad_reply_checker board;

    always #2 aclk = ~aclk;

    dhcp_reply_wpad_extractor #(
        .MAX_OPTIONS_BYTES(OPTIONS_LIMIT)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    // receiver: a pending hold-off wins, otherwise random back-pressure
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // every result beat is checked against the oldest pending one
    always @(posedge aclk) begin
        dwpad_pkg::result_t seen;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            seen.item_kind  = m_axis_tuser[0];
            seen.url_byte   = m_axis_tdata[7:0];
            seen.verdict_ok = m_axis_tdata[8];
            seen.is_last    = m_axis_tlast;
            board.check_result(seen);
        end
    end

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(255));
    endfunction

    // nonzero, so a url is not cut short by accident
    function automatic logic [7:0] text_byte();
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic void add_noise(input int n);
        repeat (n) dgram.push_back(any_byte());
    endfunction

    function automatic void cut_to(input int n);
        while (dgram.size() > n) void'(dgram.pop_back());
    endfunction

    // bootreply header with random fill, the given xid and the cookie
    function automatic void begin_reply(input logic [31:0] xid);
        dgram.delete();
        dgram.push_back(OP_BOOTREPLY);
        for (int i = 1; i < 236; i++) begin
            if (i >= 4 && i <= 7) dgram.push_back(xid[8*(7-i) +: 8]);
            else dgram.push_back(any_byte());
        end
        for (int i = 0; i < 4; i++) dgram.push_back(MAGIC_COOKIE[8*(3-i) +: 8]);
    endfunction

    function automatic void add_option(input logic [7:0] code, input int len,
                                       input bit text_only);
        dgram.push_back(code);
        dgram.push_back(8'(len));
        repeat (len) dgram.push_back(text_only ? text_byte() : any_byte());
    endfunction

    function automatic void add_msgtype(input logic [7:0] len, input logic [7:0] value);
        dgram.push_back(OPT_MSGTYPE);
        dgram.push_back(len);
        dgram.push_back(value);
    endfunction

    // any code the walk just skips over, pad included
    function automatic void add_filler();
        logic [7:0] code;
        do code = any_byte();
        while (code == OPT_MSGTYPE || code == OPT_WPAD || code == OPT_END);
        add_option(code, $urandom_range(0, 16), 1'b0);
    endfunction

    function automatic void add_wpad();
        int len;
        int stop;
        len = $urandom_range(99);
        if (len < 10) len = 0;
        else if (len < 92) len = $urandom_range(1, 40);
        else len = 255;
        stop = ($urandom_range(99) < 15) ? $urandom_range(0, len) : -1;
        dgram.push_back(OPT_WPAD);
        dgram.push_back(8'(len));
        for (int i = 0; i < len; i++) dgram.push_back(i == stop ? 8'd0 : text_byte());
    endfunction

    // mostly well-formed replies with random content, some broken or noise
    function automatic void build_random_reply(input logic [31:0] xid);
        int shape;
        int spot;
        shape = $urandom_range(99);
        if (shape < 5) begin
            dgram.delete();
            add_noise($urandom_range(1, 300));
            return;
        end
        begin_reply(xid);
        if (shape < 13) begin
            // spoil op, one xid byte or one cookie byte
            case ($urandom_range(2))
                0: spot = 0;
                1: spot = $urandom_range(4, 7);
                default: spot = $urandom_range(236, 239);
            endcase
            dgram[spot] = dgram[spot] ^ text_byte();
        end
        repeat ($urandom_range(0, 2)) add_filler();
        if ($urandom_range(99) < 70) begin
            if ($urandom_range(99) < 85) add_msgtype(8'd1, MSG_ACK);
            else add_msgtype(8'($urandom_range(0, 2)), any_byte());
        end
        repeat ($urandom_range(0, 2)) add_filler();
        if ($urandom_range(99) < 85) add_wpad();
        if ($urandom_range(99) < 10) begin
            dgram.push_back(OPT_END);
            dgram.push_back(any_byte());
        end else if ($urandom_range(99) < 30) begin
            add_noise($urandom_range(1, 12));
        end
        shape = $urandom_range(99);
        if (shape < 12) cut_to($urandom_range(1, dgram.size()));
        else if (shape < 20) add_noise(int'($urandom_range(548, 600)) - dgram.size());
    endfunction

    // one input beat; entered and left at a falling edge
    task automatic push_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge aclk); while (!s_axis_tready);
        board.note_rx_byte(b, last);
        @(negedge aclk);
    endtask

    task automatic send_dgram();
        foreach (dgram[i]) push_byte(dgram[i], i == dgram.size() - 1);
    endtask

    // wait for every pending result, then let the pipeline settle
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (board.pending() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    // xid register write, only while the block is idle
    task automatic write_xid(input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        board.xid = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [31:0] xid_now;

        board         = new();
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        send_idle_pct = 25;
        recv_idle_pct = 80;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // good ack reply with a url while xid still holds its reset value
        begin_reply(32'h0);
        add_msgtype(8'd1, MSG_ACK);
        add_option(OPT_WPAD, 12, 1'b1);
        send_dgram();
        // short datagram, then a single-beat one
        dgram.delete();
        dgram.push_back(OP_BOOTREPLY);
        add_noise(9);
        send_dgram();
        dgram.delete();
        dgram.push_back(8'hff);
        send_dgram();
        drain_results();

        xid_now = 32'hffff_ffff;
        write_xid(xid_now);

        // pad and unknown codes skipped, wpad of length zero still counts as found
        begin_reply(xid_now);
        add_option(OPT_PAD, 2, 1'b0);
        add_option(8'd1, 0, 1'b0);
        add_option(OPT_WPAD, 0, 1'b0);
        dgram.push_back(8'h41);
        send_dgram();
        // end option
        begin_reply(xid_now);
        dgram.push_back(OPT_END);
        dgram.push_back(8'h00);
        send_dgram();
        // option code on the final beat
        begin_reply(xid_now);
        add_option(8'd12, 3, 1'b0);
        dgram.push_back(OPT_WPAD);
        send_dgram();
        // msgtype with bad length, length on the final beat, value not ack
        begin_reply(xid_now);
        add_msgtype(8'd2, MSG_ACK);
        dgram.push_back(MSG_ACK);
        add_option(OPT_WPAD, 4, 1'b1);
        send_dgram();
        begin_reply(xid_now);
        dgram.push_back(OPT_MSGTYPE);
        dgram.push_back(8'd1);
        send_dgram();
        begin_reply(xid_now);
        add_msgtype(8'd1, MSG_OFFER);
        add_option(OPT_WPAD, 4, 1'b1);
        send_dgram();
        // wpad length on the final beat, nothing follows
        begin_reply(xid_now);
        dgram.push_back(OPT_WPAD);
        dgram.push_back(8'd5);
        send_dgram();
        // zero byte ends the url early, the rest is ignored
        begin_reply(xid_now);
        add_option(OPT_WPAD, 8, 1'b1);
        dgram[dgram.size() - 6] = 8'h00;
        send_dgram();
        // url cut by the end of the datagram: last beat gives url byte and verdict
        begin_reply(xid_now);
        add_option(OPT_WPAD, 20, 1'b1);
        cut_to(dgram.size() - 14);
        send_dgram();
        // longest url, every bit set
        begin_reply(xid_now);
        dgram.push_back(OPT_WPAD);
        dgram.push_back(8'hff);
        repeat (255) dgram.push_back(8'hff);
        send_dgram();
        // option walk runs past the end of the datagram
        begin_reply(xid_now);
        add_option(8'd7, 200, 1'b0);
        cut_to(dgram.size() - 180);
        send_dgram();
        // too long: url bytes already out, verdict fails
        begin_reply(xid_now);
        add_option(OPT_WPAD, 10, 1'b1);
        add_noise(560 - dgram.size());
        send_dgram();
        // long enough for the position counter to saturate
        begin_reply(xid_now);
        add_option(OPT_WPAD, 3, 1'b1);
        add_noise(1100 - dgram.size());
        send_dgram();
        // header faults on op, last xid byte and last cookie byte
        begin_reply(xid_now);
        dgram[0] = 8'h01;
        add_option(OPT_WPAD, 4, 1'b1);
        send_dgram();
        begin_reply(xid_now);
        dgram[7] = dgram[7] ^ 8'h01;
        add_option(OPT_WPAD, 4, 1'b1);
        send_dgram();
        begin_reply(xid_now);
        dgram[239] = dgram[239] ^ 8'h80;
        add_option(OPT_WPAD, 4, 1'b1);
        send_dgram();
        // header only, no options at all
        begin_reply(xid_now);
        send_dgram();
        drain_results();

        // random replies in three idling regimes, a fresh xid for each
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 25;
                    recv_idle_pct = 80;
                    xid_now = $urandom();
                end
                1: begin
                    send_idle_pct = 80;
                    recv_idle_pct = 25;
                    xid_now = 32'h0;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    xid_now = $urandom();
                end
            endcase
            write_xid(xid_now);
            if (ph == 2) begin
                // long url while the receiver holds off, so the result queue
                // fills up and input beats stall
                begin_reply(xid_now);
                add_msgtype(8'd1, MSG_ACK);
                add_option(OPT_WPAD, 200, 1'b1);
                @(posedge aclk);
                hold_left = 500;
                @(negedge aclk);
                send_dgram();
            end
            repeat (RANDOM_REPLIES) begin
                build_random_reply(xid_now);
                send_dgram();
            end
            drain_results();
        end

        if (board.errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #6000000;
        $display("testbench failed");
        $finish;
    end

endmodule
